>>> rtl/core/lfs_pkg.sv
// lfs_pkg: shared constants and types for the linear fade sequencer
// no dependencies; imported by linear_fade_sequencer
package lfs_pkg;

    localparam int CHANNELS     = 4;
    localparam int CHANNEL_BITS = 8;
    localparam int TIME_BITS    = 32;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_MODE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_DELAY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BEGIN       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEST        = 3'd4;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // finish codes
    localparam logic [1:0] FIN_BEGIN = 2'd1;
    localparam logic [1:0] FIN_DEST  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ONCE    = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_WRAP    = 2'd2,
        MODE_SMOOTH  = 2'd3
    } t_play_mode;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TIME = 7'b0000010,
        S_PREP = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MODE = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

>>> rtl/core/linear_fade_sequencer.sv
// linear_fade_sequencer: top level, command sequencer with a shared multiply and divide unit
// depends on lfs_pkg
//
// Each transaction is one command (add ticks, set elapsed, finish). A time update that is
// applied and not blocked by a finished run recomputes the channels one after another: a
// multiply step takes the channel span times the clamped elapsed time, then a restoring
// divider divides by the duration, one quotient bit a cycle, CHANNEL_BITS bits per channel.
// With a zero duration the multiply and divide are skipped and the channels jump to the
// end point; such an update, like a pass that reaches full progress, also takes the mode
// step. A finish, an ignored update or an update on a finished run goes straight to the
// done state. o_ready rises as the result is handed to the output register. A result
// waiting there does not hold off acceptance, but the next transaction stays in the
// sequencer until the output register is free.
module linear_fade_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [lfs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lfs_pkg::TIME_BITS-1:0]      i_cfg_wdata,
    // command channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [lfs_pkg::TIME_BITS-1:0]      i_time_amount,
    input  logic [1:0]                         i_finish_mode,
    input  logic [lfs_pkg::TIME_BITS-1:0]      i_now_time,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lfs_pkg::CHANNEL_BITS-1:0]   o_value_ch0,
    output logic [lfs_pkg::CHANNEL_BITS-1:0]   o_value_ch1,
    output logic [lfs_pkg::CHANNEL_BITS-1:0]   o_value_ch2,
    output logic [lfs_pkg::CHANNEL_BITS-1:0]   o_value_ch3,
    output logic                               o_done_flag,
    output logic                               o_reverse_flag,
    output logic                               o_end_pulse,
    output logic                               o_was_applied
);
    import lfs_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int TB     = TIME_BITS;
    localparam int PACKW  = CHANNELS * CB + TB;
    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_IW = (CB > 1) ? $clog2(CB) : 1;
    localparam int PW     = CB + TB;

    // configuration
    logic [TB-1:0] r_duration;
    t_play_mode    r_play_mode;
    logic [TB-1:0] r_begin;
    logic [TB-1:0] r_dest;

    // run state
    logic [TB-1:0] r_elapsed;
    logic [TB-1:0] r_start_stamp;
    logic          r_backward;
    logic          r_finished;
    logic [CB-1:0] r_chan [CHANNELS];

    // transaction in flight
    logic [1:0]    r_cmd;
    logic [TB-1:0] r_amount;
    logic [1:0]    r_fmode;
    logic [TB-1:0] r_now;
    logic          r_pulse;
    logic          r_applied;
    logic          r_full;
    logic [TB-1:0] r_e;

    // shared multiply / divide unit
    logic [CH_IW-1:0]  r_ch;
    logic [BIT_IW-1:0] r_bit;
    logic [TB-1:0]     r_rem;
    logic [CB-1:0]     r_lo;

    // output register
    logic          r_out_valid;
    logic [CB-1:0] r_out_chan [CHANNELS];
    logic          r_out_done;
    logic          r_out_rev;
    logic          r_out_pulse;
    logic          r_out_applied;

    t_state r_state;
    t_state n_state;

    // unpacked channel begin and destination values; bits beyond the register read as zero
    logic [PACKW-1:0] w_begin_ext;
    logic [PACKW-1:0] w_dest_ext;
    logic [CB-1:0]    w_begin [CHANNELS];
    logic [CB-1:0]    w_dest  [CHANNELS];

    assign w_begin_ext = {{(PACKW-TB){1'b0}}, r_begin};
    assign w_dest_ext  = {{(PACKW-TB){1'b0}}, r_dest};

    for (genvar g = 0; g < CHANNELS; g++) begin : g_unpack
        assign w_begin[g] = w_begin_ext[g*CB +: CB];
        assign w_dest[g]  = w_dest_ext[g*CB +: CB];
    end

    // datapath signals
    logic [TB:0]   w_sum;
    logic [TB-1:0] w_emin;
    logic [CB-1:0] w_b;
    logic [CB-1:0] w_d;
    logic          w_up;
    logic [CB-1:0] w_mag;
    logic [PW-1:0] w_prod;
    logic [TB:0]   w_trial;
    logic [TB:0]   w_diff;
    logic          w_ge;
    logic [CB-1:0] w_q;
    logic [CB-1:0] w_newval;
    logic          w_ch_last;
    logic          w_bit_last;
    logic          w_out_free;

    always_comb begin
        w_sum      = {1'b0, r_elapsed} + {1'b0, r_amount};
        w_emin     = (r_elapsed < r_duration) ? r_elapsed : r_duration;
        w_b        = w_begin[r_ch];
        w_d        = w_dest[r_ch];
        w_up       = (w_d >= w_b);
        w_mag      = w_up ? (w_d - w_b) : (w_b - w_d);
        w_prod     = PW'(w_mag) * PW'(r_e);
        // restoring step: bring down the next dividend bit
        w_trial    = {r_rem, r_lo[CB-1]};
        w_diff     = w_trial - {1'b0, r_duration};
        w_ge       = (w_trial >= {1'b0, r_duration});
        w_q        = CB'({r_lo, w_ge});
        w_newval   = w_up ? (w_b + w_q) : (w_b - w_q);
        w_ch_last  = (r_ch == CH_IW'(CHANNELS - 1));
        w_bit_last = (r_bit == BIT_IW'(CB - 1));
        w_out_free = !r_out_valid || i_ready;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_TIME;
                end
            end
            S_TIME: begin
                if ((r_cmd == CMD_ADD || r_cmd == CMD_SET) && !(r_now < r_start_stamp)
                    && !r_finished) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PREP: begin
                n_state = (r_duration == '0) ? S_MODE : S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_bit_last) begin
                    if (!w_ch_last) begin
                        n_state = S_MUL;
                    end else if (r_full) begin
                        n_state = S_MODE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MODE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration    <= TB'(1000);
            r_play_mode   <= MODE_ONCE;
            r_begin       <= '0;
            r_dest        <= '0;
            r_elapsed     <= '0;
            r_start_stamp <= '0;
            r_backward    <= 1'b0;
            r_finished    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_DURATION:    r_duration    <= i_cfg_wdata;
                    CFG_PLAY_MODE:   r_play_mode   <= t_play_mode'(i_cfg_wdata[1:0]);
                    CFG_START_DELAY: r_start_stamp <= i_cfg_wdata;
                    CFG_BEGIN:       r_begin       <= i_cfg_wdata;
                    CFG_DEST:        r_dest        <= i_cfg_wdata;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_TIME: begin
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SET) begin
                        if (!(r_now < r_start_stamp)) begin
                            if (r_cmd == CMD_ADD) begin
                                // saturate on overflow
                                r_elapsed <= w_sum[TB] ? '1 : w_sum[TB-1:0];
                            end else begin
                                r_elapsed <= r_amount;
                            end
                        end
                    end else if (r_cmd == CMD_FINISH) begin
                        r_finished <= 1'b1;
                        if (r_fmode == FIN_BEGIN) begin
                            for (int i = 0; i < CHANNELS; i++) r_chan[i] <= w_begin[i];
                        end else if (r_fmode == FIN_DEST) begin
                            for (int i = 0; i < CHANNELS; i++) r_chan[i] <= w_dest[i];
                        end
                    end
                end
                S_PREP: begin
                    // zero duration jumps straight to the end point
                    if (r_duration == '0) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_chan[i] <= r_backward ? w_begin[i] : w_dest[i];
                        end
                    end
                end
                S_DIV: begin
                    if (w_bit_last) begin
                        r_chan[r_ch] <= w_newval;
                    end
                end
                S_MODE: begin
                    unique case (r_play_mode)
                        MODE_ONCE: begin
                            r_finished <= 1'b1;
                            for (int i = 0; i < CHANNELS; i++) r_chan[i] <= w_dest[i];
                        end
                        MODE_REVERSE: begin
                            if (!r_backward) begin
                                r_backward    <= 1'b1;
                                r_elapsed     <= '0;
                                r_start_stamp <= r_now;
                            end else begin
                                r_finished <= 1'b1;
                                for (int i = 0; i < CHANNELS; i++) r_chan[i] <= w_begin[i];
                            end
                        end
                        MODE_WRAP: begin
                            for (int i = 0; i < CHANNELS; i++) r_chan[i] <= w_begin[i];
                            r_elapsed     <= '0;
                            r_start_stamp <= r_now;
                        end
                        MODE_SMOOTH: begin
                            r_backward    <= !r_backward;
                            r_elapsed     <= '0;
                            r_start_stamp <= r_now;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // transaction registers and the shared unit
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd     <= i_cmd;
                r_amount  <= i_time_amount;
                r_fmode   <= i_finish_mode;
                r_now     <= i_now_time;
                r_pulse   <= 1'b0;
                r_applied <= 1'b1;
            end
            S_TIME: begin
                if (r_cmd == CMD_ADD || r_cmd == CMD_SET) begin
                    if (r_now < r_start_stamp) begin
                        r_applied <= 1'b0;
                    end
                end else if (r_cmd != CMD_FINISH) begin
                    r_applied <= 1'b0;
                end
            end
            S_PREP: begin
                r_full <= (r_duration == '0) || (r_elapsed >= r_duration);
                r_e    <= r_backward ? (r_duration - w_emin) : w_emin;
                r_ch   <= '0;
            end
            S_MUL: begin
                // high part is below the duration since the quotient fits in CB bits
                r_rem <= w_prod[PW-1:CB];
                r_lo  <= w_prod[CB-1:0];
                r_bit <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[TB-1:0] : w_trial[TB-1:0];
                r_lo  <= w_q;
                r_bit <= r_bit + BIT_IW'(1);
                if (w_bit_last) begin
                    r_ch <= r_ch + CH_IW'(1);
                end
            end
            S_MODE: begin
                r_pulse <= 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_out_chan[i] <= r_chan[i];
            end
            r_out_done    <= r_finished;
            r_out_rev     <= r_backward;
            r_out_pulse   <= r_pulse;
            r_out_applied <= r_applied;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_value_ch0    = r_out_chan[0];
    assign o_value_ch1    = r_out_chan[1];
    assign o_value_ch2    = r_out_chan[2];
    assign o_value_ch3    = r_out_chan[3];
    assign o_done_flag    = r_out_done;
    assign o_reverse_flag = r_out_rev;
    assign o_end_pulse    = r_out_pulse;
    assign o_was_applied  = r_out_applied;

endmodule
